FILE: src/dcg_pkg.sv
// ----------------------------------------------------------------------------
// dcg_pkg: shared constants for the disk geometry block
// Field widths, sector limits and the sectors-per-track choices.
// ----------------------------------------------------------------------------
`default_nettype none

package dcg_pkg;

  localparam int unsigned SizeW  = 64;
  localparam int unsigned SecW   = 28;  // capped sector count fits here
  localparam int unsigned CthW   = 20;  // cylinders times heads
  localparam int unsigned CylW   = 16;
  localparam int unsigned HeadW  = 5;
  localparam int unsigned SptW   = 8;
  localparam int unsigned GeomW  = 32;
  localparam int unsigned SectorShift = 9;   // 512-byte sectors
  localparam int unsigned CylLimitLog = 10;  // 1024 cylinders

  localparam logic [SecW-1:0] SectorCap  = SecW'(65535 * 16 * 255);
  localparam logic [SecW-1:0] LargeLimit = SecW'(65535 * 16 * 63);
  localparam logic [SecW-1:0] Fail17Limit = SecW'(17 * 16385);
  localparam logic [SecW-1:0] Fail31Limit = SecW'(31 * 16384);

  localparam logic [SptW-1:0] Spt17  = SptW'(17);
  localparam logic [SptW-1:0] Spt31  = SptW'(31);
  localparam logic [SptW-1:0] Spt63  = SptW'(63);
  localparam logic [SptW-1:0] Spt255 = SptW'(255);

  localparam logic [HeadW-1:0] MinHeads = HeadW'(4);
  localparam logic [HeadW-1:0] MaxHeads = HeadW'(16);
  localparam int unsigned CylRound = (1 << CylLimitLog) - 1;

endpackage

`default_nettype wire

FILE: src/dcg_in_if.sv
// ----------------------------------------------------------------------------
// dcg_in_if: size channel
// Valid/ready channel carrying the disk capacity in bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface dcg_in_if;
  logic                        valid;
  logic                        ready;
  logic [dcg_pkg::SizeW-1:0]   disk_size_bytes;

  modport source (output valid, output disk_size_bytes, input ready);
  modport sink   (input valid, input disk_size_bytes, output ready);
endinterface

`default_nettype wire

FILE: src/dcg_out_if.sv
// ----------------------------------------------------------------------------
// dcg_out_if: geometry channel
// Valid/ready channel carrying the computed geometry.
// ----------------------------------------------------------------------------
`default_nettype none

interface dcg_out_if;
  logic                        valid;
  logic                        ready;
  logic [dcg_pkg::GeomW-1:0]   geometry_word;
  logic [dcg_pkg::CylW-1:0]    cylinder_count;
  logic [dcg_pkg::HeadW-1:0]   head_count;
  logic [dcg_pkg::SptW-1:0]    sectors_per_track;

  modport source (output valid, output geometry_word, output cylinder_count,
                  output head_count, output sectors_per_track, input ready);
  modport sink   (input valid, input geometry_word, input cylinder_count,
                  input head_count, input sectors_per_track, output ready);
endinterface

`default_nettype wire

FILE: src/dcg_div_cell.sv
// ----------------------------------------------------------------------------
// dcg_div_cell: one restoring division step
// Brings down one dividend bit, subtracts the divisor if it fits and
// shifts the quotient bit in; registered with its own valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

module dcg_div_cell #(
  parameter int unsigned DivW  = 8,
  parameter int unsigned WorkW = 20,
  parameter int unsigned SideW = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire logic [DivW-1:0]   rem_i,
  input  wire logic [WorkW-1:0]  work_i,
  input  wire logic [DivW-1:0]   div_i,
  input  wire logic [SideW-1:0]  side_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output logic [DivW-1:0]        rem_o,
  output logic [WorkW-1:0]       work_o,
  output logic [DivW-1:0]        div_o,
  output logic [SideW-1:0]       side_o
);

  logic              valid_q;
  logic [DivW-1:0]   rem_d, rem_q;
  logic [WorkW-1:0]  work_d, work_q;
  logic [DivW-1:0]   div_q;
  logic [SideW-1:0]  side_q;
  logic [DivW:0]     trial;
  logic              take;

  always_comb begin
    trial  = {rem_i, work_i[WorkW-1]};
    take   = (trial >= {1'b0, div_i});
    rem_d  = take ? DivW'(trial - {1'b0, div_i}) : trial[DivW-1:0];
    work_d = {work_i[WorkW-2:0], take};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q  <= rem_d;
      work_q <= work_d;
      div_q  <= div_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign work_o  = work_q;
  assign div_o   = div_q;
  assign side_o  = side_q;

endmodule

`default_nettype wire

FILE: src/dcg_div_chain.sv
// ----------------------------------------------------------------------------
// dcg_div_chain: row of division cells
// One cell per quotient bit; the quotient leaves in work_o.
// ----------------------------------------------------------------------------
`default_nettype none

module dcg_div_chain #(
  parameter int unsigned DivW  = 8,
  parameter int unsigned WorkW = 20,
  parameter int unsigned SideW = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire logic [DivW-1:0]   rem_i,
  input  wire logic [WorkW-1:0]  work_i,
  input  wire logic [DivW-1:0]   div_i,
  input  wire logic [SideW-1:0]  side_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output logic [WorkW-1:0]       work_o,
  output logic [DivW-1:0]        div_o,
  output logic [SideW-1:0]       side_o
);

  logic              v    [WorkW+1];
  logic              rdy  [WorkW+1];
  logic [DivW-1:0]   rem  [WorkW+1];
  logic [WorkW-1:0]  work [WorkW+1];
  logic [DivW-1:0]   dv   [WorkW+1];
  logic [SideW-1:0]  side [WorkW+1];

  assign v[0]    = valid_i;
  assign ready_o = rdy[0];
  assign rem[0]  = rem_i;
  assign work[0] = work_i;
  assign dv[0]   = div_i;
  assign side[0] = side_i;

  for (genvar i = 0; i < WorkW; i++) begin : g_cell
    dcg_div_cell #(
      .DivW  (DivW),
      .WorkW (WorkW),
      .SideW (SideW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v[i]),
      .ready_o (rdy[i]),
      .rem_i   (rem[i]),
      .work_i  (work[i]),
      .div_i   (dv[i]),
      .side_i  (side[i]),
      .valid_o (v[i+1]),
      .ready_i (rdy[i+1]),
      .rem_o   (rem[i+1]),
      .work_o  (work[i+1]),
      .div_o   (dv[i+1]),
      .side_o  (side[i+1])
    );
  end

  assign rdy[WorkW] = ready_i;
  assign valid_o    = v[WorkW];
  assign work_o     = work[WorkW];
  assign div_o      = dv[WorkW];
  assign side_o     = side[WorkW];

endmodule

`default_nettype wire

FILE: src/dcg_front.sv
// ----------------------------------------------------------------------------
// dcg_front: sector count and track size choice
// Stage one turns bytes into capped sectors; stage two picks sectors per
// track straight from the sector count.
// ----------------------------------------------------------------------------
`default_nettype none

module dcg_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  output logic                            ready_o,
  input  wire logic [dcg_pkg::SizeW-1:0]  size_i,
  output logic                            valid_o,
  input  wire logic                       ready_i,
  output logic [dcg_pkg::SecW-1:0]        sectors_o,
  output logic [dcg_pkg::SptW-1:0]        spt_o,
  output logic                            sel17_o
);

  localparam int unsigned RawW = dcg_pkg::SizeW - dcg_pkg::SectorShift;

  logic                        v1_q, v2_q;
  logic                        rdy1, rdy2;
  logic [RawW-1:0]             raw;
  logic [dcg_pkg::SecW-1:0]    sec_d, sec1_q, sec2_q;
  logic [dcg_pkg::SptW-1:0]    spt_d, spt_q;
  logic                        hit, fail17;

  assign raw   = size_i[dcg_pkg::SizeW-1:dcg_pkg::SectorShift];
  assign sec_d = (raw > RawW'(dcg_pkg::SectorCap)) ? dcg_pkg::SectorCap
                                                   : raw[dcg_pkg::SecW-1:0];

  // 17-sector cylinders-times-heads lands exactly on k*1024 for some k of 4..16
  always_comb begin
    hit = 1'b0;
    for (int k = 4; k <= 16; k++) begin
      if (sec1_q[18:10] == 9'(17 * k)) hit = 1'b1;
    end
    hit    = hit && (sec1_q[9:0] < 10'd17) && (sec1_q < dcg_pkg::Fail17Limit);
    fail17 = (sec1_q >= dcg_pkg::Fail17Limit) || hit;
    if (sec1_q >= dcg_pkg::LargeLimit) begin
      spt_d = dcg_pkg::Spt255;
    end else if (!fail17) begin
      spt_d = dcg_pkg::Spt17;
    end else if (sec1_q < dcg_pkg::Fail31Limit) begin
      spt_d = dcg_pkg::Spt31;
    end else begin
      spt_d = dcg_pkg::Spt63;
    end
  end

  assign rdy2    = !v2_q || ready_i;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) sec1_q <= sec_d;
    if (rdy2 && v1_q) begin
      sec2_q <= sec1_q;
      spt_q  <= spt_d;
    end
  end

  assign valid_o   = v2_q;
  assign sectors_o = sec2_q;
  assign spt_o     = spt_q;
  assign sel17_o   = (spt_q == dcg_pkg::Spt17);

endmodule

`default_nettype wire

FILE: src/disk_chs_geometry.sv
// Pipeline: size word to geometry word through 2 front stages,
// 20 cells for sectors / track size and 16 for / heads.
// Throughput: one word per cycle unless the output stalls; every stage and cell has its own valid
// and takes a new word as soon as its successor moves on.
// Reset: rst_ni async active low empties all stages; no other state.
// ----------------------------------------------------------------------------
// disk_chs_geometry: virtual-disk cylinder/head/sector geometry
// Sector count, track size choice, then two rows of division cells.
// ----------------------------------------------------------------------------
`default_nettype none

module disk_chs_geometry (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dcg_in_if.sink     size_i,
  dcg_out_if.source  geom_o
);

  localparam int unsigned CthW  = dcg_pkg::CthW;
  localparam int unsigned SecW  = dcg_pkg::SecW;
  localparam int unsigned SptW  = dcg_pkg::SptW;
  localparam int unsigned HeadW = dcg_pkg::HeadW;
  localparam int unsigned CylW  = dcg_pkg::CylW;

  logic                 f_valid, f_ready, f_sel17;
  logic [SecW-1:0]      f_sec;
  logic [SptW-1:0]      f_spt;

  logic                 c_valid, c_ready;
  logic [CthW-1:0]      cth;
  logic [SptW-1:0]      c_spt;
  logic                 c_sel17;

  logic [CthW:0]        rounded;
  logic [HeadW:0]       ceil_heads;
  logic [HeadW-1:0]     heads;

  logic [CylW-1:0]      cyl;
  logic [HeadW-1:0]     o_heads;
  logic [SptW-1:0]      o_spt;

  dcg_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (size_i.valid),
    .ready_o   (size_i.ready),
    .size_i    (size_i.disk_size_bytes),
    .valid_o   (f_valid),
    .ready_i   (f_ready),
    .sectors_o (f_sec),
    .spt_o     (f_spt),
    .sel17_o   (f_sel17)
  );

  // sectors / track size, quotient is cylinders times heads
  dcg_div_chain #(
    .DivW  (SptW),
    .WorkW (CthW),
    .SideW (1)
  ) u_spt_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .ready_o (f_ready),
    .rem_i   (f_sec[SecW-1:CthW]),
    .work_i  (f_sec[CthW-1:0]),
    .div_i   (f_spt),
    .side_i  (f_sel17),
    .valid_o (c_valid),
    .ready_i (c_ready),
    .work_o  (cth),
    .div_o   (c_spt),
    .side_o  (c_sel17)
  );

  // heads rounded up to cover 1024 cylinders, never below four; sixteen unless track size is 17
  always_comb begin
    rounded    = {1'b0, cth} + (CthW+1)'(dcg_pkg::CylRound);
    ceil_heads = rounded[dcg_pkg::CylLimitLog +: (HeadW+1)];
    if (!c_sel17) begin
      heads = dcg_pkg::MaxHeads;
    end else if (ceil_heads < (HeadW+1)'(dcg_pkg::MinHeads)) begin
      heads = dcg_pkg::MinHeads;
    end else begin
      heads = ceil_heads[HeadW-1:0];
    end
  end

  dcg_div_chain #(
    .DivW  (HeadW),
    .WorkW (CylW),
    .SideW (SptW)
  ) u_head_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_valid),
    .ready_o (c_ready),
    .rem_i   ({1'b0, cth[CthW-1:CylW]}),
    .work_i  (cth[CylW-1:0]),
    .div_i   (heads),
    .side_i  (c_spt),
    .valid_o (geom_o.valid),
    .ready_i (geom_o.ready),
    .work_o  (cyl),
    .div_o   (o_heads),
    .side_o  (o_spt)
  );

  assign geom_o.cylinder_count    = cyl;
  assign geom_o.head_count        = o_heads;
  assign geom_o.sectors_per_track = o_spt;
  assign geom_o.geometry_word     = {cyl, (8-HeadW)'(0), o_heads, o_spt};

`ifndef SYNTHESIS
  a_heads_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    geom_o.valid |-> (o_heads >= dcg_pkg::MinHeads) && (o_heads <= dcg_pkg::MaxHeads))
    else $error("head count out of range");

  a_spt_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    geom_o.valid |-> (o_spt == dcg_pkg::Spt17) || (o_spt == dcg_pkg::Spt31) ||
                     (o_spt == dcg_pkg::Spt63) || (o_spt == dcg_pkg::Spt255))
    else $error("illegal sectors per track");

  a_wide_heads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (geom_o.valid && (o_spt != dcg_pkg::Spt17)) |-> (o_heads == dcg_pkg::MaxHeads))
    else $error("wide track without sixteen heads");

  a_cth_fits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid |-> ({1'b0, cth[CthW-1:CylW]} < heads))
    else $error("cylinder count would overflow");
`endif

endmodule

`default_nettype wire
